[rtl/core/pcfrl_pkg.sv]
`default_nettype none

package pcfrl_pkg;

    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned CLIENT_W   = 10;
    // wide enough to hold the largest client count (4096)
    localparam int unsigned COUNT_W    = 13;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned CLIENT_COUNT_DEF = 1024;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAT_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINE        = 3'd4;

    localparam logic [LEVEL_W-1:0] RST_FLOOD_LIMIT    = 16'd1000;
    localparam logic [LEVEL_W-1:0] RST_WARN_THRESHOLD = 16'd500;
    localparam logic [LEVEL_W-1:0] RST_COMMAND_WEIGHT = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_CHAT_WEIGHT    = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_DECLINE        = 16'd10;

    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_CHAT    = 2'd1,
        OP_TICK    = 2'd2,
        OP_CONNECT = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 operation;
        logic [CLIENT_W-1:0] client;
    } t_req;

    typedef struct packed {
        logic               kicked;
        logic               warned;
        logic               accepted;
        logic [LEVEL_W-1:0] level_after;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/core/per_client_flood_rate_limiter.sv]
// Per-client flood rate limiter (leaky bucket). A table in on-chip memory holds one 16-bit
// flood level per client. A command or chat request adds its configured weight (saturating
// at 65535); a level at or above flood_limit blocks the event and flags a kick, otherwise
// the event is accepted and warns when the level is above warn_threshold. A decay tick
// lowers every level by decline_per_tick with a floor of zero, and a connect clears the
// client's level. Clients at or beyond CLIENT_COUNT are ignored and answered as accepted
// with level 0. Timing: after reset the table is swept to zero, one entry per cycle, over
// all CLIENT_COUNT entries with the request channel not ready (configuration writes work).
// A command, chat or connect request makes one registered memory read as it transfers,
// then one pass through the shared add/subtract unit with the write-back. A decay tick
// moves one table entry per cycle through that same unit and the
// single memory write port. One request is in flight at a time; a new request can be
// taken while the previous result still waits in the output register.
`default_nettype none

module per_client_flood_rate_limiter #(
    parameter int unsigned CLIENT_COUNT = pcfrl_pkg::CLIENT_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // request channel
    input  wire logic                             i_req_valid,
    output logic                                  o_req_ready,
    input  wire pcfrl_pkg::t_req                  i_req,

    // result channel
    output logic                                  o_rsp_valid,
    input  wire logic                             i_rsp_ready,
    output pcfrl_pkg::t_rsp                       o_rsp,

    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pcfrl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pcfrl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pcfrl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                  pready
);
    import pcfrl_pkg::*;

    // table address width, at least one bit
    localparam int unsigned AW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
    localparam logic [AW-1:0]      LAST_IDX     = AW'(CLIENT_COUNT - 1);
    localparam logic [COUNT_W-1:0] CLIENT_LIMIT = COUNT_W'(CLIENT_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVENT,
        ST_TICK,
        ST_TICK_LAST
    } t_state;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0]   r_flood_limit;
    logic [LEVEL_W-1:0]   r_warn_threshold;
    logic [LEVEL_W-1:0]   r_command_weight;
    logic [LEVEL_W-1:0]   r_chat_weight;
    logic [LEVEL_W-1:0]   r_decline;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // low two address bits are byte offsets within a register
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flood_limit    <= RST_FLOOD_LIMIT;
            r_warn_threshold <= RST_WARN_THRESHOLD;
            r_command_weight <= RST_COMMAND_WEIGHT;
            r_chat_weight    <= RST_CHAT_WEIGHT;
            r_decline        <= RST_DECLINE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FLOOD_LIMIT:    r_flood_limit    <= pwdata[LEVEL_W-1:0];
                REG_WARN_THRESHOLD: r_warn_threshold <= pwdata[LEVEL_W-1:0];
                REG_COMMAND_WEIGHT: r_command_weight <= pwdata[LEVEL_W-1:0];
                REG_CHAT_WEIGHT:    r_chat_weight    <= pwdata[LEVEL_W-1:0];
                REG_DECLINE:        r_decline        <= pwdata[LEVEL_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // read-back mux, unused upper bits read as zero
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FLOOD_LIMIT:    prdata[LEVEL_W-1:0] = r_flood_limit;
            REG_WARN_THRESHOLD: prdata[LEVEL_W-1:0] = r_warn_threshold;
            REG_COMMAND_WEIGHT: prdata[LEVEL_W-1:0] = r_command_weight;
            REG_CHAT_WEIGHT:    prdata[LEVEL_W-1:0] = r_chat_weight;
            REG_DECLINE:        prdata[LEVEL_W-1:0] = r_decline;
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // level table: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] mem [CLIENT_COUNT];
    logic [LEVEL_W-1:0] r_rd_data;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [LEVEL_W-1:0] mem_wd;
    logic [AW-1:0]      mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;          // sweep read pointer
    logic [AW-1:0]      r_wr_idx, n_wr_idx;    // sweep write-back pointer, one behind
    logic               r_pend, n_pend;        // read data holds an entry to write back
    t_op                r_op, n_op;
    logic [CLIENT_W-1:0] r_client, n_client;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    logic [AW-1:0]      ev_addr;
    logic               ev_in_range;
    logic               out_free;

    // shared arithmetic unit: weight add for events, decline subtract for ticks
    logic               unit_sub;
    logic [LEVEL_W-1:0] unit_b;
    logic [LEVEL_W-1:0] unit_y;

    assign unit_sub = (r_state == ST_TICK) || (r_state == ST_TICK_LAST);
    assign unit_b   = unit_sub ? r_decline
                    : ((r_op == OP_COMMAND) ? r_command_weight : r_chat_weight);

    pcfrl_addsub u_addsub (
        .i_a   (r_rd_data),
        .i_b   (unit_b),
        .i_sub (unit_sub),
        .o_y   (unit_y)
    );

    assign ev_addr     = AW'(r_client);
    assign ev_in_range = ({{(COUNT_W-CLIENT_W){1'b0}}, r_client} < CLIENT_LIMIT);
    // the output register can take a new result this cycle
    assign out_free    = !r_rsp_valid || i_rsp_ready;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wr_idx    = r_wr_idx;
        n_pend      = r_pend;
        n_op        = r_op;
        n_client    = r_client;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = '0;
        mem_ra      = r_idx;

        unique case (r_state)
            // zero the table after reset, one entry a cycle
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            // read the client's entry as the request transfers
            ST_IDLE: begin
                mem_ra = AW'(i_req.client);
                if (i_req_valid) begin
                    n_op     = i_req.operation;
                    n_client = i_req.client;
                    if (i_req.operation == OP_TICK) begin
                        n_state = ST_TICK;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                    end else begin
                        n_state = ST_EVENT;
                    end
                end
            end

            // update one entry and build the result
            ST_EVENT: begin
                mem_ra = ev_addr;  // keeps the read data steady while stalled
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                    n_rsp       = '{kicked: 1'b0, warned: 1'b0, accepted: 1'b1,
                                    level_after: '0};
                    if (ev_in_range) begin
                        mem_wa = ev_addr;
                        unique case (r_op)
                            OP_CONNECT: begin
                                mem_we = 1'b1;
                                mem_wd = '0;
                            end
                            OP_COMMAND, OP_CHAT: begin
                                mem_we            = 1'b1;
                                mem_wd            = unit_y;
                                n_rsp.level_after = unit_y;
                                if (unit_y >= r_flood_limit) begin
                                    n_rsp.kicked   = 1'b1;
                                    n_rsp.accepted = 1'b0;
                                end else begin
                                    n_rsp.warned = (unit_y > r_warn_threshold);
                                end
                            end
                            OP_TICK: ;  // ticks never reach this state
                        endcase
                    end
                end
            end

            // decay sweep: read entry i while writing back entry i-1
            ST_TICK: begin
                mem_ra = r_idx;
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_idx;
                    mem_wd = unit_y;
                end
                n_wr_idx = r_idx;
                n_pend   = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_TICK_LAST;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            // write back the last entry together with the tick result
            ST_TICK_LAST: begin
                mem_ra = r_wr_idx;
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_wa      = r_wr_idx;
                    mem_wd      = unit_y;
                    n_state     = ST_IDLE;
                    n_pend      = 1'b0;
                    n_rsp_valid = 1'b1;
                    n_rsp       = '{kicked: 1'b0, warned: 1'b0, accepted: 1'b1,
                                    level_after: '0};
                end
            end

            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_wr_idx    <= '0;
            r_pend      <= 1'b0;
            r_op        <= OP_COMMAND;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wr_idx    <= n_wr_idx;
            r_pend      <= n_pend;
            r_op        <= n_op;
            r_rsp_valid <= n_rsp_valid;
        end
        // payload, no reset needed
        r_client <= n_client;
        r_rsp    <= n_rsp;
    end

endmodule

`default_nettype wire

[rtl/core/pcfrl_addsub.sv]
`default_nettype none

// saturating add, or subtract with a floor of zero
module pcfrl_addsub (
    input  wire logic [pcfrl_pkg::LEVEL_W-1:0] i_a,
    input  wire logic [pcfrl_pkg::LEVEL_W-1:0] i_b,
    input  wire logic                          i_sub,
    output logic      [pcfrl_pkg::LEVEL_W-1:0] o_y
);
    import pcfrl_pkg::*;

    logic [LEVEL_W:0] opb;
    logic [LEVEL_W:0] sum;

    assign opb = i_sub ? (~{1'b0, i_b} + {{LEVEL_W{1'b0}}, 1'b1}) : {1'b0, i_b};
    assign sum = {1'b0, i_a} + opb;

    always_comb begin
        if (i_sub) begin
            // top bit set means a borrow
            o_y = sum[LEVEL_W] ? '0 : sum[LEVEL_W-1:0];
        end else begin
            o_y = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/core/pcfrl_checker.sv]
`default_nettype none

module pcfrl_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_req_valid,
    input wire logic            o_req_ready,
    input wire logic            o_rsp_valid,
    input wire logic            i_rsp_ready,
    input wire pcfrl_pkg::t_rsp o_rsp
);
    import pcfrl_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed or dropped while stalled");

    // one request at a time: ready drops after each transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    // table clear runs right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_req_ready)
        else $error("request channel ready during table clear");

    // a kick is exactly a blocked event
    a_kick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.kicked != o_rsp.accepted) && !(o_rsp.kicked && o_rsp.warned))
        else $error("inconsistent kick, warn and accept flags");

    // a warning needs a level above the threshold, so never zero
    a_warn_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.warned |-> o_rsp.level_after != '0)
        else $error("warning with zero level");

endmodule

bind per_client_flood_rate_limiter pcfrl_checker u_pcfrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

`default_nettype wire

[tb/sv/per_client_flood_rate_limiter_tb.sv]
`timescale 1ns / 1ps

module per_client_flood_rate_limiter_tb;
    import pcfrl_pkg::*;

    localparam int unsigned CLIENTS     = CLIENT_COUNT_DEF;
    // number of registers in the map, anything at or above is unmapped
    localparam int unsigned REG_COUNT   = 5;
    localparam int unsigned HOT_COUNT   = 8;
    // settle time after the last result has arrived
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned PHASE_ITEMS = 170;
    localparam int unsigned PRINT_CAP   = 50;
    // clearing sweep, ~60 full-table ticks, long gaps and stalls, all taken several times
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // shadow of the flood table and registers, plus the queue of expected results
    class flood_scoreboard;
        logic [LEVEL_W-1:0] level_table [CLIENTS];
        logic [LEVEL_W-1:0] flood_limit;
        logic [LEVEL_W-1:0] warn_threshold;
        logic [LEVEL_W-1:0] command_weight;
        logic [LEVEL_W-1:0] chat_weight;
        logic [LEVEL_W-1:0] decline;
        t_rsp               expected_q [$];
        int unsigned        errors;

        function new();
            foreach (level_table[i]) level_table[i] = '0;
            flood_limit    = RST_FLOOD_LIMIT;
            warn_threshold = RST_WARN_THRESHOLD;
            command_weight = RST_COMMAND_WEIGHT;
            chat_weight    = RST_CHAT_WEIGHT;
            decline        = RST_DECLINE;
            errors         = 0;
        endfunction

        // only the low 16 bits land, unmapped indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FLOOD_LIMIT:    flood_limit    = value[LEVEL_W-1:0];
                REG_WARN_THRESHOLD: warn_threshold = value[LEVEL_W-1:0];
                REG_COMMAND_WEIGHT: command_weight = value[LEVEL_W-1:0];
                REG_CHAT_WEIGHT:    chat_weight    = value[LEVEL_W-1:0];
                REG_DECLINE:        decline        = value[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // update the shadow table and queue the answer for one accepted request
        function void note_request(t_req req);
            t_rsp             rsp;
            logic [LEVEL_W:0] sum;
            logic [LEVEL_W-1:0] weight;
            rsp = '0;
            rsp.accepted = 1'b1;
            if (req.operation == OP_TICK) begin
                // leak every entry, floor at zero
                foreach (level_table[i]) begin
                    if (level_table[i] > decline) begin
                        level_table[i] = level_table[i] - decline;
                    end else begin
                        level_table[i] = '0;
                    end
                end
            end else if (req.client < CLIENTS) begin
                if (req.operation == OP_CONNECT) begin
                    level_table[req.client] = '0;
                end else begin
                    weight = (req.operation == OP_COMMAND) ? command_weight : chat_weight;
                    sum = {1'b0, level_table[req.client]} + {1'b0, weight};
                    // saturate instead of wrapping
                    if (sum > {1'b0, LEVEL_MAX}) sum = {1'b0, LEVEL_MAX};
                    level_table[req.client] = sum[LEVEL_W-1:0];
                    rsp.level_after = sum[LEVEL_W-1:0];
                    // a blocked event still keeps its raised level
                    if (sum >= {1'b0, flood_limit}) begin
                        rsp.kicked   = 1'b1;
                        rsp.accepted = 1'b0;
                    end else begin
                        rsp.warned = (sum > {1'b0, warn_threshold});
                    end
                end
            end
            expected_q.push_back(rsp);
        endfunction

        task report(string what);
            if (errors < PRINT_CAP) $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.kicked !== want.kicked)
                report($sformatf("kicked %b, want %b", got.kicked, want.kicked));
            if (got.warned !== want.warned)
                report($sformatf("warned %b, want %b", got.warned, want.warned));
            if (got.accepted !== want.accepted)
                report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.level_after !== want.level_after)
                report($sformatf("level_after %0d, want %0d", got.level_after,
                                 want.level_after));
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    t_req                  i_req       = '0;
    logic                  i_rsp_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;

    logic                  o_req_ready;
    logic                  o_rsp_valid;
    t_rsp                  o_rsp;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    flood_scoreboard       sb;
    // while set, neither side inserts gaps or stalls
    bit                    calm = 1'b0;
    int unsigned           stall_left = 0;
    int unsigned           cycles = 0;
    logic [CLIENT_W-1:0]   hot_clients [HOT_COUNT];

    per_client_flood_rate_limiter #(
        .CLIENT_COUNT (CLIENTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            i_rsp_ready <= 1'b0;
            stall_left = pick_pause() - 1;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // watch both channels; values read here are the ones present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) sb.check_result(o_rsp);
            if (i_req_valid && o_req_ready) sb.note_request(i_req);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("per_client_flood_rate_limiter_tb failed");
            $finish;
        end
    end

    // optional gap, then hold the request until its transfer
    task send_request(t_req req, int unsigned gap);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    function automatic t_req make_request(t_op op, logic [CLIENT_W-1:0] client);
        t_req req;
        req.operation = op;
        req.client    = client;
        return req;
    endfunction

    // mostly a few hot clients so levels climb into warn and kick territory
    function automatic t_req random_request();
        t_req        req;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            req.operation = OP_COMMAND;
        end else if (roll < 85) begin
            req.operation = OP_CHAT;
        end else if (roll < 96) begin
            req.operation = OP_CONNECT;
        end else begin
            req.operation = OP_TICK;
        end
        if ($urandom_range(0, 4) != 0) begin
            req.client = hot_clients[$urandom_range(0, HOT_COUNT - 1)];
        end else begin
            req.client = CLIENT_W'($urandom_range(0, CLIENTS - 1));
        end
        return req;
    endfunction

    // setup then access; the upper data bits carry noise that must be dropped
    task write_register(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word    = {16'($urandom_range(0, 65535)), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, word);
        // leave the bus idle before the next write
        @(posedge i_clk);
    endtask

    // stop sending, let every pending result arrive, then settle
    task wait_idle();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task run_random(int unsigned count);
        int unsigned gap;
        for (int n = 0; n < count; n++) begin
            // every 40 items decide whether this stretch runs without idling
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = (calm || $urandom_range(0, 99) < 50) ? 0 : pick_pause();
            send_request(random_request(), gap);
        end
        calm = 1'b0;
    endtask

    // new register setting (plus one write to an unmapped slot), new hot set, random traffic
    task run_phase(logic [LEVEL_W-1:0] limit, logic [LEVEL_W-1:0] warn,
                   logic [LEVEL_W-1:0] cmd, logic [LEVEL_W-1:0] chat,
                   logic [LEVEL_W-1:0] leak, int unsigned count);
        wait_idle();
        write_register(REG_FLOOD_LIMIT, limit);
        write_register(REG_WARN_THRESHOLD, warn);
        write_register(REG_COMMAND_WEIGHT, cmd);
        write_register(REG_CHAT_WEIGHT, chat);
        write_register(REG_DECLINE, leak);
        write_register(CFG_IDX_W'(REG_COUNT + $urandom_range(0, 2)),
                       16'($urandom_range(0, 65535)));
        foreach (hot_clients[i]) hot_clients[i] = CLIENT_W'($urandom_range(0, CLIENTS - 1));
        run_random(count);
    endtask

    initial begin
        int unsigned limit_pick;
        sb = new();
        foreach (hot_clients[i]) hot_clients[i] = CLIENT_W'($urandom_range(0, CLIENTS - 1));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: one client climbs through warn into kick,
        // and keeps its level after the block
        for (int k = 0; k < 11; k++) send_request(make_request(OP_COMMAND, '0), 0);
        send_request(make_request(OP_CHAT, '1), 0);
        send_request(make_request(OP_CHAT, '1), 0);
        send_request(make_request(OP_TICK, '0), 0);
        send_request(make_request(OP_CONNECT, '0), 0);
        send_request(make_request(OP_COMMAND, '0), 0);
        send_request(make_request(OP_CHAT, CLIENT_W'(682)), 0);
        send_request(make_request(OP_CONNECT, CLIENT_W'(341)), 0);
        send_request(make_request(OP_TICK, '1), 0);
        send_request(make_request(OP_COMMAND, '1), 0);

        // random traffic under the reset settings
        run_random(PHASE_ITEMS);

        // extremes: saturation at full scale, warn always, zero chat weight, full leak
        run_phase('1, '0, '1, '0, '1, PHASE_ITEMS);
        // limit of zero blocks everything, no leak
        run_phase('0, '1, 16'd1, 16'd7, '0, PHASE_ITEMS);
        // zero weights with the smallest limit, the table only drains
        run_phase(16'd1, '0, '0, '0, 16'd1, PHASE_ITEMS);

        for (int p = 0; p < 5; p++) begin
            limit_pick = $urandom_range(300, 4000);
            run_phase(LEVEL_W'(limit_pick), LEVEL_W'($urandom_range(0, limit_pick)),
                      LEVEL_W'($urandom_range(1, 500)), LEVEL_W'($urandom_range(1, 500)),
                      LEVEL_W'($urandom_range(0, 400)), PHASE_ITEMS);
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("per_client_flood_rate_limiter_tb passed");
        end else begin
            $display("per_client_flood_rate_limiter_tb failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pcfrl_pkg.sv
rtl/core/pcfrl_addsub.sv
rtl/core/per_client_flood_rate_limiter.sv
rtl/core/pcfrl_checker.sv
tb/sv/per_client_flood_rate_limiter_tb.sv
